// ----- src/cbt_pkg.sv -----
// conv5x5 bias tanh layer: shared types, sizes and the tanh table
// no dependencies
package cbt_pkg;

  localparam int KERNELS_DEF   = 6;
  localparam int KSIZE_DEF     = 5;
  localparam int OUT_SIZE_DEF  = 28;
  localparam int IMG_WIDTH_DEF = 32;

  localparam int DATA_W = 16;
  localparam int PROD_W = 2 * DATA_W;
  localparam int FRAC_W = 12;

  typedef enum logic [1:0] {
    KIND_WEIGHT = 2'd0,
    KIND_BIAS   = 2'd1,
    KIND_PIXEL  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic [2:0]               kernel_index;
    logic [4:0]               tap_index;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]               out_kernel;
    logic [4:0]               out_row;
    logic [4:0]               out_col;
    logic signed [DATA_W-1:0] activation;
    logic                     last;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic op_valid;
  } mac_ctl_t;

  // tanh at segment midpoints 1/16, 3/16 ... 63/16 in q2.14
  localparam logic [14:0] TANH_POS [32] = '{
    15'd1023,  15'd3036,  15'd4960,  15'd6743,  15'd8353,  15'd9771,  15'd10993, 15'd12027,
    15'd12888, 15'd13595, 15'd14171, 15'd14634, 15'd15005, 15'd15300, 15'd15533, 15'd15718,
    15'd15863, 15'd15977, 15'd16066, 15'd16136, 15'd16190, 15'd16233, 15'd16266, 15'd16292,
    15'd16312, 15'd16328, 15'd16341, 15'd16350, 15'd16358, 15'd16363, 15'd16368, 15'd16372
  };

  function automatic logic signed [DATA_W-1:0] tanh_lookup(input logic [5:0] idx);
    logic [DATA_W-1:0] mag;
    begin
      if (idx[5]) begin
        mag = DATA_W'(TANH_POS[idx[4:0]]);
        tanh_lookup = $signed(mag);
      end else begin
        mag = DATA_W'(TANH_POS[~idx[4:0]]);
        tanh_lookup = -$signed(mag);
      end
    end
  endfunction

endpackage

// ----- src/cbt_ram.sv -----
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
module cbt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/cbt_mac.sv -----
// shared multiply-accumulate unit: registered product, then accumulate
// depends on cbt_pkg
module cbt_mac #(
  parameter int ACC_W = 40
) (
  input  logic                             clk,
  input  logic                             rst,
  input  cbt_pkg::mac_ctl_t                ctl,
  input  logic signed [cbt_pkg::DATA_W-1:0] a,
  input  logic signed [cbt_pkg::DATA_W-1:0] b,
  output logic signed [ACC_W-1:0]          acc
);
  import cbt_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic                     prod_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctl.op_valid;
    end
    prod <= a * b;
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + ACC_W'(prod);
    end
  end

endmodule

// ----- src/conv5x5_bias_tanh_layer.sv -----
// conv5x5 bias tanh layer top: sequencer, line buffer, window and output register
// depends on cbt_pkg, cbt_ram, cbt_mac
//
// usage: items enter on item_valid/item_stall/item, results leave on
// result_valid/result_stall/result; an item moves when valid is high and
// stall is low.
// weight and bias loads are taken while idle and give no result.
// a pixel first goes through the line buffer read and window shift; when
// the window lies inside the frame it then runs KERNELS passes of the one
// shared multiplier over KSIZE*KSIZE weights plus the bias, each pass
// ending with its result written into the output register. item_stall is
// high for that whole time. the bias is held in the weight memory and
// enters as one more product, times 1.0.
// a stalled result holds the sequencer before the next kernel result; the
// last result of a pixel may still wait while the next item is taken.
// reset (synchronous) clears the pixel counters, the window and the line
// buffer valid bits; weights and biases must be loaded before use.
module conv5x5_bias_tanh_layer #(
  parameter int KERNELS   = cbt_pkg::KERNELS_DEF,
  parameter int KSIZE     = cbt_pkg::KSIZE_DEF,
  parameter int OUT_SIZE  = cbt_pkg::OUT_SIZE_DEF,
  parameter int IMG_WIDTH = cbt_pkg::IMG_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  cbt_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_stall,
  output cbt_pkg::out_item_t result
);
  import cbt_pkg::*;

  localparam int TAPS     = KSIZE * KSIZE;
  localparam int SLOTS    = TAPS + 1;
  localparam int WDEPTH   = KERNELS * SLOTS;
  localparam int WAW      = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int TW       = $clog2(TAPS + 3);
  localparam int WINAW    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int KW       = (KERNELS > 1) ? $clog2(KERNELS) : 1;
  localparam int COLW     = $clog2(IMG_WIDTH);
  localparam int LB_ROWS  = (KSIZE > 1) ? KSIZE - 1 : 1;
  localparam int LB_W     = LB_ROWS * DATA_W;
  localparam int ACC_W    = PROD_W + $clog2(SLOTS + 1) + 1;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd67108863);
  localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(64'sd67108864);
  localparam logic signed [DATA_W-1:0] BIAS_SCALE = DATA_W'(1 << FRAC_W);

  typedef enum logic [1:0] {S_IDLE, S_LB, S_MAC, S_OUT} state_t;

  state_t                   state;
  logic [COLW-1:0]          row;
  logic [COLW-1:0]          col;
  logic [IMG_WIDTH-1:0]     lb_valid;
  logic signed [DATA_W-1:0] win [TAPS];
  logic signed [DATA_W-1:0] pix;
  logic [KW-1:0]            kern;
  logic [TW-1:0]            tap;
  logic [WAW-1:0]           waddr;
  logic                     rd_valid;
  logic [TW-1:0]            rd_tap;
  logic [4:0]               orow;
  logic [4:0]               ocol;

  logic                     w_we;
  logic [WAW-1:0]           w_waddr;
  logic [DATA_W-1:0]        w_rdata;
  logic [LB_W-1:0]          lb_rdata;
  logic [LB_W-1:0]          lb_wdata;
  logic signed [DATA_W-1:0] column [KSIZE];
  logic                     issue;
  logic                     emit;
  logic [31:0]              r32;
  logic [31:0]              c32;
  logic [31:0]              wa32;
  mac_ctl_t                 mctl;
  logic signed [DATA_W-1:0] mac_b;
  logic signed [ACC_W-1:0]  acc;
  logic [5:0]               tidx;
  logic                     out_free;

  assign item_stall = (state != S_IDLE);
  assign issue      = (state == S_MAC) && (tap <= TW'(TAPS));
  assign out_free   = !result_valid || !result_stall;

  always_comb begin
    wa32 = 32'(item.kernel_index) * SLOTS;
    w_we = 1'b0;
    w_waddr = '0;
    if (state == S_IDLE && item_valid && 32'(item.kernel_index) < KERNELS) begin
      if (item.kind == KIND_WEIGHT && 32'(item.tap_index) < TAPS) begin
        w_we    = 1'b1;
        w_waddr = WAW'(wa32 + 32'(item.tap_index));
      end else if (item.kind == KIND_BIAS) begin
        w_we    = 1'b1;
        w_waddr = WAW'(wa32 + TAPS);
      end
    end
  end

  cbt_ram #(.WIDTH(DATA_W), .DEPTH(WDEPTH)) u_wram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (item.value),
    .raddr (waddr),
    .rdata (w_rdata)
  );

  always_comb begin
    lb_wdata = '0;
    for (int i = 0; i < KSIZE; i++) begin
      if (i < KSIZE - 1) begin
        column[i] = lb_valid[col] ? $signed(lb_rdata[i*DATA_W +: DATA_W]) : '0;
      end else begin
        column[i] = pix;
      end
    end
    for (int i = 0; i < KSIZE - 1; i++) begin
      lb_wdata[i*DATA_W +: DATA_W] = column[i+1];
    end
  end

  cbt_ram #(.WIDTH(LB_W), .DEPTH(IMG_WIDTH)) u_lbram (
    .clk   (clk),
    .we    (state == S_LB),
    .waddr (col),
    .wdata (lb_wdata),
    .raddr (col),
    .rdata (lb_rdata)
  );

  always_comb begin
    r32  = 32'(row);
    c32  = 32'(col);
    emit = (r32 >= KSIZE - 1) && (c32 >= KSIZE - 1) &&
           (r32 - (KSIZE - 1) < OUT_SIZE) && (c32 - (KSIZE - 1) < OUT_SIZE);
    mac_b = (rd_tap < TW'(TAPS)) ? win[rd_tap[WINAW-1:0]] : BIAS_SCALE;
    mctl.op_valid = rd_valid;
    mctl.clear    = (state == S_LB && emit) || (state == S_OUT && out_free);
  end

  cbt_mac #(.ACC_W(ACC_W)) u_mac (
    .clk (clk),
    .rst (rst),
    .ctl (mctl),
    .a   ($signed(w_rdata)),
    .b   (mac_b),
    .acc (acc)
  );

  always_comb begin
    if (acc > SAT_HI) begin
      tidx = 6'd63;
    end else if (acc < SAT_LO) begin
      tidx = 6'd0;
    end else begin
      tidx = {~acc[26], acc[25:21]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      row          <= '0;
      col          <= '0;
      lb_valid     <= '0;
      result_valid <= 1'b0;
      rd_valid     <= 1'b0;
      for (int i = 0; i < TAPS; i++) begin
        win[i] <= '0;
      end
    end else begin
      rd_valid <= issue;
      rd_tap   <= tap;
      if (issue) begin
        waddr <= waddr + 1'b1;
      end
      if (result_valid && !result_stall && state != S_OUT) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid && item.kind == KIND_PIXEL) begin
            pix   <= item.value;
            state <= S_LB;
          end
        end
        S_LB: begin
          lb_valid[col] <= 1'b1;
          for (int i = 0; i < KSIZE; i++) begin
            for (int j = 0; j < KSIZE - 1; j++) begin
              win[i*KSIZE+j] <= win[i*KSIZE+j+1];
            end
            win[i*KSIZE+KSIZE-1] <= column[i];
          end
          orow <= 5'(r32 - (KSIZE - 1));
          ocol <= 5'(c32 - (KSIZE - 1));
          if (c32 == IMG_WIDTH - 1) begin
            col <= '0;
            row <= (r32 == IMG_WIDTH - 1) ? '0 : row + 1'b1;
          end else begin
            col <= col + 1'b1;
          end
          kern  <= '0;
          tap   <= '0;
          waddr <= '0;
          state <= emit ? S_MAC : S_IDLE;
        end
        S_MAC: begin
          tap <= tap + 1'b1;
          if (tap == TW'(TAPS + 2)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            result_valid      <= 1'b1;
            result.out_kernel <= 3'(kern);
            result.out_row    <= orow;
            result.out_col    <= ocol;
            result.activation <= tanh_lookup(tidx);
            result.last       <= (32'(kern) == KERNELS - 1);
            tap               <= '0;
            if (32'(kern) == KERNELS - 1) begin
              state <= S_IDLE;
            end else begin
              kern  <= kern + 1'b1;
              state <= S_MAC;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- dv/tb_conv5x5_bias_tanh_layer.sv -----
// testbench for conv5x5_bias_tanh_layer: loads kernels and biases, streams pixel frames
// with random gaps and stalls, and checks every activation against a built-in predictor
// depends on cbt_pkg and the rtl of the layer
module tb_conv5x5_bias_tanh_layer;
  import cbt_pkg::*;

  localparam int NK = KERNELS_DEF;
  localparam int KS = KSIZE_DEF;
  localparam int TAPS = KS * KS;
  localparam int IW = IMG_WIDTH_DEF;
  localparam int OS = OUT_SIZE_DEF;
  localparam int RANDOM_ITEMS = 200;
  localparam int CYCLE_LIMIT = 1000000;

  class conv_scoreboard;
    out_item_t pending[$];
    int errors;
    int matched;
    int pixels;
    int wraps;
    int weight_mem[NK][TAPS];
    int bias_mem[NK];
    int lines[KS-1][IW];
    int win[KS][KS];
    int row;
    int col;
    int tanh_mag[32] = '{
      1023, 3036, 4960, 6743, 8353, 9771, 10993, 12027,
      12888, 13595, 14171, 14634, 15005, 15300, 15533, 15718,
      15863, 15977, 16066, 16136, 16190, 16233, 16266, 16292,
      16312, 16328, 16341, 16350, 16358, 16363, 16368, 16372
    };

    function int activation_of(longint acc);
      int idx;
      if (acc > 64'sd67108863) acc = 67108863;
      if (acc < -64'sd67108864) acc = -67108864;
      idx = int'((acc + 67108864) >>> 21);
      if (idx >= 32) return tanh_mag[idx-32];
      return -tanh_mag[31-idx];
    endfunction

    function void note_item(in_item_t it);
      int column[KS];
      longint acc;
      out_item_t o;
      if (it.kind == KIND_WEIGHT) begin
        if (it.kernel_index < NK && it.tap_index < TAPS)
          weight_mem[it.kernel_index][it.tap_index] = it.value;
        return;
      end
      if (it.kind == KIND_BIAS) begin
        if (it.kernel_index < NK) bias_mem[it.kernel_index] = it.value;
        return;
      end
      if (it.kind != KIND_PIXEL) return;
      pixels++;
      for (int i = 0; i < KS-1; i++) column[i] = lines[i][col];
      column[KS-1] = it.value;
      for (int i = 0; i < KS-1; i++) lines[i][col] = column[i+1];
      for (int i = 0; i < KS; i++) begin
        for (int j = 0; j < KS-1; j++) win[i][j] = win[i][j+1];
        win[i][KS-1] = column[i];
      end
      if (row >= KS-1 && col >= KS-1 && row-(KS-1) < OS && col-(KS-1) < OS) begin
        for (int k = 0; k < NK; k++) begin
          acc = longint'(bias_mem[k]) * 4096;
          for (int i = 0; i < KS; i++)
            for (int j = 0; j < KS; j++)
              acc += longint'(weight_mem[k][i*KS+j]) * longint'(win[i][j]);
          o.out_kernel = 3'(k);
          o.out_row = 5'(row - (KS-1));
          o.out_col = 5'(col - (KS-1));
          o.activation = 16'(activation_of(acc));
          o.last = (k == NK-1);
          pending.push_back(o);
        end
      end
      col++;
      if (col >= IW) begin
        col = 0;
        row++;
        if (row >= IW) begin
          row = 0;
          wraps++;
        end
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result kernel %0d row %0d col %0d act %0d last %0d",
                 $time, got.out_kernel, got.out_row, got.out_col, got.activation, got.last);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: mismatch expected k%0d r%0d c%0d act %0d last %0d, got k%0d r%0d c%0d act %0d last %0d",
                 $time, want.out_kernel, want.out_row, want.out_col, want.activation,
                 want.last, got.out_kernel, got.out_row, got.out_col, got.activation,
                 got.last);
        errors++;
      end else begin
        matched++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  in_item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  out_item_t result;
  logic calm = 1'b0;
  int cycles = 0;
  conv_scoreboard sb = new();

  conv5x5_bias_tanh_layer dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
    result_stall <= calm ? 1'b0 : ($urandom_range(99) < 14);
  end

  function automatic logic signed [15:0] pick_value(int mag);
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return 16'($signed($urandom_range(2*mag)) - mag);
    endcase
  endfunction

  task automatic send(logic [1:0] kind, int kidx, int tidx, logic signed [15:0] val);
    in_item_t it;
    it.kind = kind;
    it.kernel_index = 3'(kidx);
    it.tap_index = 5'(tidx);
    it.value = val;
    while (!calm && $urandom_range(99) < 14) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    sb.note_item(it);
  endtask

  task automatic load_kernels(int mag);
    for (int k = 0; k < NK; k++) begin
      for (int t = 0; t < TAPS; t++) send(KIND_WEIGHT, k, t, pick_value(mag));
      send(KIND_BIAS, k, 0, pick_value(4096));
    end
  endtask

  initial begin
    int r;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    load_kernels(900);

    // ignored items and out of range loads, then alternating full-scale pixels
    send(KIND_NONE, 7, 31, 16'sh7fff);
    send(KIND_WEIGHT, 6, 3, 16'sh8000);
    send(KIND_WEIGHT, 7, 31, 16'sh7fff);
    send(KIND_WEIGHT, 2, 25, 16'sh1234);
    send(KIND_BIAS, 6, 0, 16'sh7fff);
    send(KIND_BIAS, 7, 31, 16'sh8000);
    for (int i = 0; i < 16; i++)
      send(KIND_PIXEL, 0, 0, i[0] ? 16'sh7fff : 16'sh8000);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm <= (n >= 130 && n < 190);
      if (n == 160) begin
        item_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
      end
      r = $urandom_range(99);
      if (r < 88) send(KIND_PIXEL, $urandom_range(7), $urandom_range(31), pick_value(4096));
      else if (r < 93) send(KIND_WEIGHT, $urandom_range(7), $urandom_range(31), pick_value(900));
      else if (r < 97) send(KIND_BIAS, $urandom_range(7), $urandom_range(31), pick_value(8192));
      else send(KIND_NONE, $urandom_range(7), $urandom_range(31), pick_value(32767));
    end
    item_valid <= 1'b0;
    calm <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);

    $display("%0d pixels streamed over %0d frame wraps, %0d activations matched",
             sb.pixels, sb.wraps, sb.matched);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ----- files.f -----
src/cbt_pkg.sv
src/cbt_ram.sv
src/cbt_mac.sv
src/conv5x5_bias_tanh_layer.sv
dv/tb_conv5x5_bias_tanh_layer.sv
